// File: design/tbr_pkg.sv
// Shared types, constants and the 5x7 font table of the text bitplane renderer.
package tbr_pkg;

  localparam int PLANE_BYTES = 4000;
  localparam int PLANE_AW    = 12;
  localparam int CUR_Y_MAX   = 511;
  localparam int CFG_DW      = 9;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_STOPPED   = 2'd1;
  localparam logic [1:0] STATUS_BAD_START = 2'd2;

  localparam logic [1:0] CFG_START_X  = 2'd0;
  localparam logic [1:0] CFG_START_Y  = 2'd1;
  localparam logic [1:0] CFG_DRAW_RED = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [3:0] STEP_LAST = 4'd13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CLEAR,
    ST_DRAW,
    ST_DRAIN,
    ST_READ,
    ST_FINISH
  } tbr_state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic        plane;
    logic [11:0] byte_addr;
  } tbr_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic [7:0] cursor_col;
    logic [8:0] cursor_row;
  } tbr_out_t;

  typedef struct packed {
    logic                we;
    logic [PLANE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [PLANE_AW-1:0] raddr;
  } tbr_ram_req_t;

  typedef logic [4:0][7:0] glyph_t;

  function automatic glyph_t tbr_mk(input logic [7:0] c0, input logic [7:0] c1,
                                    input logic [7:0] c2, input logic [7:0] c3,
                                    input logic [7:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  function automatic glyph_t tbr_glyph(input logic [7:0] code);
    glyph_t g;
    case (code)
      8'h20: g = tbr_mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'h21: g = tbr_mk(8'h00, 8'h00, 8'h5F, 8'h00, 8'h00);
      8'h2E: g = tbr_mk(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      8'h2C: g = tbr_mk(8'h00, 8'h80, 8'h60, 8'h00, 8'h00);
      8'h3A: g = tbr_mk(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      8'h2D: g = tbr_mk(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      8'h5F: g = tbr_mk(8'h40, 8'h40, 8'h40, 8'h40, 8'h40);
      8'h2F: g = tbr_mk(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
      8'h2B: g = tbr_mk(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
      8'h3D: g = tbr_mk(8'h14, 8'h14, 8'h14, 8'h14, 8'h14);
      8'h28: g = tbr_mk(8'h00, 8'h1C, 8'h22, 8'h41, 8'h00);
      8'h29: g = tbr_mk(8'h00, 8'h41, 8'h22, 8'h1C, 8'h00);
      8'h30: g = tbr_mk(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      8'h31: g = tbr_mk(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      8'h32: g = tbr_mk(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      8'h33: g = tbr_mk(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      8'h34: g = tbr_mk(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      8'h35: g = tbr_mk(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      8'h36: g = tbr_mk(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      8'h37: g = tbr_mk(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      8'h38: g = tbr_mk(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h39: g = tbr_mk(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      8'h41: g = tbr_mk(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      8'h42: g = tbr_mk(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h43: g = tbr_mk(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      8'h44: g = tbr_mk(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      8'h45: g = tbr_mk(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      8'h46: g = tbr_mk(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
      8'h47: g = tbr_mk(8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A);
      8'h48: g = tbr_mk(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      8'h49: g = tbr_mk(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      8'h4A: g = tbr_mk(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
      8'h4B: g = tbr_mk(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
      8'h4C: g = tbr_mk(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      8'h4D: g = tbr_mk(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      8'h4E: g = tbr_mk(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      8'h4F: g = tbr_mk(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      8'h50: g = tbr_mk(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      8'h51: g = tbr_mk(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
      8'h52: g = tbr_mk(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      8'h53: g = tbr_mk(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      8'h54: g = tbr_mk(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      8'h55: g = tbr_mk(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      8'h56: g = tbr_mk(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
      8'h57: g = tbr_mk(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
      8'h58: g = tbr_mk(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      8'h59: g = tbr_mk(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
      8'h5A: g = tbr_mk(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      default: g = tbr_mk(8'h02, 8'h01, 8'h51, 8'h09, 8'h06);
    endcase
    return g;
  endfunction

endpackage

// File: design/tbr_plane_ram.sv
// One framebuffer plane: a single-port-write, single-port-read synchronous byte memory.
module tbr_plane_ram (
  input  logic                  clk_i,
  input  tbr_pkg::tbr_ram_req_t req_i,
  output logic [7:0]            rdata_o
);
  import tbr_pkg::*;

  logic [7:0] mem [PLANE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/text_to_bitplane_renderer_unit.sv
// Top level of the text bitplane renderer: command sequencer, glyph raster and planes.
//
// The block holds a black and a red 4000-byte framebuffer plane, each in a synchronous
// memory with one write and one read port, and works on one word at a time. A clear
// sweeps both planes with 0xFF, one byte per cycle, and then gives its result; reads of a
// plane before the first clear return undefined data. A character is drawn by read-modify-write
// of up to two bytes in each of its seven pixel rows, fourteen steps issued one per cycle on
// the plane memory's ports with the previous write forwarded, and a drain state follows before
// the result. A byte read passes through a read state; a newline, a read beyond the store or
// any command that draws nothing goes straight from setup to the result. A finished result
// waits in an output register, so the next word is taken while it is held.
module text_to_bitplane_renderer_unit #(
  parameter int PANEL_WIDTH  = 122,
  parameter int PANEL_HEIGHT = 250,
  parameter int ROW_BYTES    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tbr_pkg::tbr_in_t             in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tbr_pkg::tbr_out_t            out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [tbr_pkg::CFG_DW-1:0]   cfg_data_i
);
  import tbr_pkg::*;

  localparam int FULL_RAW = $clog2((CUR_Y_MAX + 7) * ROW_BYTES + 40);
  localparam int FULL_W   = (FULL_RAW > PLANE_AW) ? FULL_RAW : PLANE_AW + 1;

  tbr_state_e state_q, state_d;
  tbr_in_t    item_q, item_d;

  logic [7:0] start_x_q;
  logic [8:0] start_y_q;
  logic       draw_red_q;

  logic [7:0] cursor_x_q, cursor_x_d;
  logic [8:0] cursor_y_q, cursor_y_d;
  logic       stopped_q, stopped_d;

  logic [1:0] res_status_q, res_status_d;
  logic [7:0] res_data_q, res_data_d;

  logic              out_valid_q, out_valid_d;
  tbr_out_t          out_word_q, out_word_d;

  logic [PLANE_AW-1:0] clr_cnt_q, clr_cnt_d;

  glyph_t              glyph_q, glyph_d;
  logic [4:0]          colv_q, colv_d;
  logic [2:0]          xo_q, xo_d;
  logic [4:0]          bx0_q, bx0_d;
  logic [FULL_W-1:0]   row_base_q, row_base_d;
  logic [9:0]          row_y_q, row_y_d;
  logic [3:0]          step_q, step_d;

  logic                p_valid_q, p_valid_d;
  logic [PLANE_AW-1:0] p_addr_q, p_addr_d;
  logic [7:0]          p_mask_q, p_mask_d;
  logic                fwd_hit_q, fwd_hit_d;
  logic [7:0]          fwd_data_q, fwd_data_d;
  logic                rd_sel_q, rd_sel_d;

  tbr_ram_req_t blk_req, red_req;
  logic [7:0]   blk_rdata, red_rdata, rdata_sel;

  logic        start_bad;
  logic [7:0]  code_f;
  logic [9:0]  wrap_sum;
  logic [8:0]  wrap_y;
  logic        wrap_stop;
  logic        need_wrap;
  logic [7:0]  x_draw;
  logic [8:0]  y_draw;

  logic [2:0]        row_r;
  logic [4:0]        row_bits;
  logic [15:0]       row_pat;
  logic [7:0]        byte_mask;
  logic [FULL_W-1:0] full_addr;
  logic [7:0]        step_mask;
  logic              issue;
  logic [7:0]        old_byte;
  logic [7:0]        new_byte;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  tbr_plane_ram u_black (
    .clk_i   (clk_i),
    .req_i   (blk_req),
    .rdata_o (blk_rdata)
  );

  tbr_plane_ram u_red (
    .clk_i   (clk_i),
    .req_i   (red_req),
    .rdata_o (red_rdata)
  );

  assign rdata_sel = rd_sel_q ? red_rdata : blk_rdata;

  assign start_bad = ({1'b0, start_x_q} >= 9'(PANEL_WIDTH)) ||
                     ({1'b0, start_y_q} >= 10'(PANEL_HEIGHT));
  assign code_f    = (item_q.char_code >= CHAR_LOWER_A && item_q.char_code <= CHAR_LOWER_Z) ?
                     item_q.char_code - CASE_OFFSET : item_q.char_code;
  assign wrap_sum  = {1'b0, cursor_y_q} + 10'd8;
  assign wrap_y    = wrap_sum[9] ? 9'(CUR_Y_MAX) : wrap_sum[8:0];
  assign wrap_stop = ({1'b0, wrap_y} + 10'd7) >= 10'(PANEL_HEIGHT);
  assign need_wrap = ({1'b0, cursor_x_q} + 9'd5) >= 9'(PANEL_WIDTH);
  assign x_draw    = need_wrap ? start_x_q : cursor_x_q;
  assign y_draw    = need_wrap ? wrap_y : cursor_y_q;

  always_comb begin
    row_r = step_q[3:1];
    for (int c = 0; c < 5; c++) begin
      row_bits[c] = glyph_q[c][row_r];
    end
    row_bits  = row_bits & colv_q;
    row_pat   = {row_bits[0], row_bits[1], row_bits[2], row_bits[3], row_bits[4], 11'b0} >> xo_q;
    byte_mask = step_q[0] ? row_pat[7:0] : row_pat[15:8];
    full_addr = row_base_q + FULL_W'(bx0_q) + FULL_W'(step_q[0]);
    step_mask = ((row_y_q < 10'(PANEL_HEIGHT)) && (full_addr < FULL_W'(PLANE_BYTES))) ?
                byte_mask : 8'h00;
    old_byte  = fwd_hit_q ? fwd_data_q : rdata_sel;
    new_byte  = old_byte & ~p_mask_q;
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    cursor_x_d   = cursor_x_q;
    cursor_y_d   = cursor_y_q;
    stopped_d    = stopped_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_word_d   = out_word_q;
    clr_cnt_d    = clr_cnt_q;
    glyph_d      = glyph_q;
    colv_d       = colv_q;
    xo_d         = xo_q;
    bx0_d        = bx0_q;
    row_base_d   = row_base_q;
    row_y_d      = row_y_q;
    step_d       = step_q;
    rd_sel_d     = rd_sel_q;
    issue        = 1'b0;
    blk_req      = '0;
    red_req      = '0;

    if (p_valid_q) begin
      if (draw_red_q) begin
        red_req.we    = 1'b1;
        red_req.waddr = p_addr_q;
        red_req.wdata = new_byte;
      end else begin
        blk_req.we    = 1'b1;
        blk_req.waddr = p_addr_q;
        blk_req.wdata = new_byte;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_word_i;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        res_status_d = STATUS_DONE;
        res_data_d   = 8'h00;
        state_d      = ST_FINISH;
        case (item_q.func)
          FUNC_CLEAR: begin
            cursor_x_d   = start_x_q;
            cursor_y_d   = start_y_q;
            stopped_d    = 1'b0;
            res_status_d = start_bad ? STATUS_BAD_START : STATUS_DONE;
            clr_cnt_d    = '0;
            state_d      = ST_CLEAR;
          end
          FUNC_DRAW: begin
            if (start_bad) begin
              res_status_d = STATUS_BAD_START;
            end else if (stopped_q) begin
              res_status_d = STATUS_STOPPED;
            end else if (item_q.char_code == CHAR_NEWLINE) begin
              cursor_x_d = start_x_q;
              cursor_y_d = wrap_y;
              if (wrap_stop) begin
                stopped_d = 1'b1;
              end
            end else if (need_wrap && wrap_stop) begin
              cursor_x_d   = start_x_q;
              cursor_y_d   = wrap_y;
              stopped_d    = 1'b1;
              res_status_d = STATUS_STOPPED;
            end else begin
              cursor_x_d = x_draw + 8'd6;
              cursor_y_d = y_draw;
              glyph_d    = tbr_glyph(code_f);
              for (int c = 0; c < 5; c++) begin
                colv_d[c] = ({1'b0, x_draw} + 9'(c)) < 9'(PANEL_WIDTH);
              end
              xo_d       = x_draw[2:0];
              bx0_d      = x_draw[7:3];
              row_base_d = FULL_W'(y_draw) * FULL_W'(ROW_BYTES);
              row_y_d    = {1'b0, y_draw};
              step_d     = '0;
              rd_sel_d   = draw_red_q;
              state_d    = ST_DRAW;
            end
          end
          FUNC_READ: begin
            if (item_q.byte_addr < 12'(PLANE_BYTES)) begin
              if (item_q.plane) begin
                red_req.re    = 1'b1;
                red_req.raddr = item_q.byte_addr;
              end else begin
                blk_req.re    = 1'b1;
                blk_req.raddr = item_q.byte_addr;
              end
              rd_sel_d = item_q.plane;
              state_d  = ST_READ;
            end
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_CLEAR: begin
        blk_req.we    = 1'b1;
        blk_req.waddr = clr_cnt_q;
        blk_req.wdata = 8'hFF;
        red_req.we    = 1'b1;
        red_req.waddr = clr_cnt_q;
        red_req.wdata = 8'hFF;
        if (clr_cnt_q == PLANE_AW'(PLANE_BYTES - 1)) begin
          state_d = ST_FINISH;
        end else begin
          clr_cnt_d = clr_cnt_q + PLANE_AW'(1);
        end
      end
      ST_DRAW: begin
        issue = (step_mask != 8'h00);
        if (issue) begin
          if (draw_red_q) begin
            red_req.re    = 1'b1;
            red_req.raddr = full_addr[PLANE_AW-1:0];
          end else begin
            blk_req.re    = 1'b1;
            blk_req.raddr = full_addr[PLANE_AW-1:0];
          end
        end
        if (step_q[0]) begin
          row_base_d = row_base_q + FULL_W'(ROW_BYTES);
          row_y_d    = row_y_q + 10'd1;
        end
        if (step_q == STEP_LAST) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_READ: begin
        res_data_d = rdata_sel;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_word_d.status     = res_status_q;
          out_word_d.read_data  = res_data_q;
          out_word_d.cursor_col = cursor_x_q;
          out_word_d.cursor_row = cursor_y_q;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    p_valid_d  = issue;
    p_addr_d   = full_addr[PLANE_AW-1:0];
    p_mask_d   = step_mask;
    fwd_hit_d  = p_valid_q && (p_addr_q == full_addr[PLANE_AW-1:0]);
    fwd_data_d = new_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_x_q   <= '0;
      start_y_q   <= '0;
      draw_red_q  <= 1'b0;
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      p_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_x_q  <= cursor_x_d;
      cursor_y_q  <= cursor_y_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
      p_valid_q   <= p_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_START_X:  start_x_q  <= cfg_data_i[7:0];
          CFG_START_Y:  start_y_q  <= cfg_data_i[8:0];
          CFG_DRAW_RED: draw_red_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    out_word_q   <= out_word_d;
    clr_cnt_q    <= clr_cnt_d;
    glyph_q      <= glyph_d;
    colv_q       <= colv_d;
    xo_q         <= xo_d;
    bx0_q        <= bx0_d;
    row_base_q   <= row_base_d;
    row_y_q      <= row_y_d;
    step_q       <= step_d;
    p_addr_q     <= p_addr_d;
    p_mask_q     <= p_mask_d;
    fwd_hit_q    <= fwd_hit_d;
    fwd_data_q   <= fwd_data_d;
    rd_sel_q     <= rd_sel_d;
  end

  a_blk_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_req.we |-> (blk_req.waddr < PLANE_AW'(PLANE_BYTES)))
    else $error("black plane write beyond the store");

  a_red_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_req.we |-> (red_req.waddr < PLANE_AW'(PLANE_BYTES)))
    else $error("red plane write beyond the store");

  a_pipe_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> (state_q == ST_DRAW || state_q == ST_DRAIN))
    else $error("pending plane write outside of a glyph draw");

  a_stop_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stopped_q) |-> $past(state_q == ST_SETUP && item_q.func == FUNC_DRAW))
    else $error("stop flag set outside of a draw command");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FINISH))
    else $error("result word appeared without a finished command");

endmodule
